// ----- src/legacy_pc_pic_pit_rtc_ports_core_assert.svh -----
// assertion macros for the legacy pc i/o core checker
`ifndef LEGACY_PC_PIC_PIT_RTC_PORTS_CORE_ASSERT_SVH
`define LEGACY_PC_PIC_PIT_RTC_PORTS_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPCIO_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpcio same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define LPCIO_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpcio next-cycle check failed");

`endif

// ----- src/lpcio_pkg.sv -----
// shared types and constants of the legacy pc i/o core
package lpcio_pkg;

  // opcodes of an input item
  localparam logic [4:0] OP_RD_PIC1_MASK = 5'd0;
  localparam logic [4:0] OP_RD_PIC2_MASK = 5'd1;
  localparam logic [4:0] OP_RD_PIC1_PEND = 5'd2;
  localparam logic [4:0] OP_RD_PIC2_PEND = 5'd3;
  localparam logic [4:0] OP_RD_TIMER     = 5'd4;
  localparam logic [4:0] OP_RD_RTC       = 5'd5;
  localparam logic [4:0] OP_RD_PORTB     = 5'd6;
  localparam logic [4:0] OP_WR_PIC1_MASK = 5'd7;
  localparam logic [4:0] OP_WR_PIC2_MASK = 5'd8;
  localparam logic [4:0] OP_PIC1_ACK     = 5'd9;
  localparam logic [4:0] OP_WR_TIMER     = 5'd10;
  localparam logic [4:0] OP_WR_TCTRL     = 5'd11;
  localparam logic [4:0] OP_WR_RTC_INDEX = 5'd12;
  localparam logic [4:0] OP_WR_RTC_DATA  = 5'd13;
  localparam logic [4:0] OP_RAISE        = 5'd14;
  localparam logic [4:0] OP_CLEAR        = 5'd15;
  localparam logic [4:0] OP_PIT_TICK     = 5'd16;
  localparam logic [4:0] OP_RTC_TICK     = 5'd17;
  localparam logic [4:0] OP_IGNORE       = 5'd18;

  // timer counters
  localparam int unsigned NUM_COUNTERS = 3;
  localparam int unsigned SPKR_COUNTER = 2;
  localparam logic [1:0]  SEL_READBACK = 2'd3;
  localparam logic [1:0]  RW_LATCH     = 2'd0;
  localparam logic [1:0]  RW_LSB_MSB   = 2'd3;
  localparam logic [2:0]  MODE_INT     = 3'd0;
  localparam logic [2:0]  MODE_RATE    = 3'd2;
  localparam logic [2:0]  MODE_SQUARE  = 3'd3;
  localparam logic [7:0]  PORTB_OUT2   = 8'h20;

  // rtc registers
  localparam logic [3:0]  RTC_IDX_STATUS_A = 4'd10;
  localparam logic [3:0]  RTC_IDX_STATUS_B = 4'd11;
  localparam logic [7:0]  RTC_IDX_MAX      = 8'd13;
  localparam logic [7:0]  STATUS_A_RESET   = 8'h26;
  localparam logic [7:0]  STATUS_A_UIP     = 8'h80;
  localparam logic [7:0]  STATUS_B_RESET   = 8'h46;
  localparam logic [7:0]  STATUS_B_FREE    = 8'h48;
  localparam logic [7:0]  STATUS_B_FIXED   = 8'h06;
  localparam int unsigned STATUS_B_PIE     = 6;
  localparam logic [31:0] RTC_PERIOD_RESET = 32'd1024;

  // one input item
  typedef struct packed {
    logic [4:0] opcode;
    logic [1:0] counter_sel;
    logic [7:0] data;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       pic_irq;
    logic       rtc_irq;
    logic       error;
  } out_item_t;

  // read byte and error flag a unit returns for one item
  typedef struct packed {
    logic [7:0] rd;
    logic       err;
  } unit_rsp_t;

  // per-counter control flags
  typedef struct packed {
    logic       wmsb;
    logic       rmsb;
    logic       latch;
    logic       out;
    logic [2:0] mode;
  } cnt_flags_t;

endpackage

// ----- src/lpcio_pic.sv -----
// interrupt controller: pending byte, enable mask and level output
module lpcio_pic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  lpcio_pkg::in_item_t  item,
  output lpcio_pkg::unit_rsp_t rsp,
  output logic                 irq
);
  import lpcio_pkg::*;

  logic [7:0] pending_r, pending_nxt;
  logic [7:0] enable_r, enable_nxt;
  logic [7:0] mask2_r, mask2_nxt;

  // decode one access
  always_comb begin
    pending_nxt = pending_r;
    enable_nxt  = enable_r;
    mask2_nxt   = mask2_r;
    rsp         = '0;
    case (item.opcode)
      OP_RD_PIC1_MASK: rsp.rd = ~enable_r;
      OP_RD_PIC2_MASK: rsp.rd = ~mask2_r;
      OP_RD_PIC1_PEND: rsp.rd = pending_r;
      OP_RD_PIC2_PEND: rsp.rd = 8'h00;
      OP_WR_PIC1_MASK: enable_nxt = ~item.data;
      OP_WR_PIC2_MASK: mask2_nxt = item.data;
      OP_PIC1_ACK: begin
        // codes 8..15 name no line
        if (!item.data[3]) pending_nxt = pending_r & ~(8'h01 << item.data[2:0]);
      end
      OP_RAISE: pending_nxt = pending_r | item.data;
      OP_CLEAR: pending_nxt = pending_r & ~item.data;
      default: ;
    endcase
  end

  // level line follows the updated state
  assign irq = |(pending_nxt & enable_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      enable_r  <= '0;
      mask2_r   <= '0;
    end else if (go) begin
      pending_r <= pending_nxt;
      enable_r  <= enable_nxt;
      mask2_r   <= mask2_nxt;
    end
  end

endmodule

// ----- src/lpcio_pit.sv -----
// three interval timer counters with latch and byte toggles
module lpcio_pit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  lpcio_pkg::in_item_t  item,
  output lpcio_pkg::unit_rsp_t rsp
);
  import lpcio_pkg::*;

  logic [15:0] count_r [NUM_COUNTERS];
  logic [15:0] count_nxt [NUM_COUNTERS];
  logic [15:0] latched_r [NUM_COUNTERS];
  logic [15:0] latched_nxt [NUM_COUNTERS];
  logic [15:0] ticks_r [NUM_COUNTERS];
  logic [15:0] ticks_nxt [NUM_COUNTERS];
  cnt_flags_t  flags_r [NUM_COUNTERS];
  cnt_flags_t  flags_nxt [NUM_COUNTERS];

  logic [1:0]  ctl_sel;
  logic [1:0]  ctl_rw;
  logic [2:0]  ctl_mode;
  logic        mode_ok;
  logic [15:0] rd_word;
  logic [15:0] hi_count;

  // control word fields
  assign ctl_sel  = item.data[7:6];
  assign ctl_rw   = item.data[5:4];
  assign ctl_mode = item.data[3:1];
  assign mode_ok  = (ctl_mode == MODE_INT) || (ctl_mode == MODE_RATE) ||
                    (ctl_mode == MODE_SQUARE);

  // per-counter next state
  always_comb begin
    rsp      = '0;
    rd_word  = '0;
    hi_count = '0;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      count_nxt[i]   = count_r[i];
      latched_nxt[i] = latched_r[i];
      ticks_nxt[i]   = ticks_r[i];
      flags_nxt[i]   = flags_r[i];
    end
    case (item.opcode)
      OP_RD_TIMER: begin
        if (item.counter_sel == SEL_READBACK) begin
          rsp.err = 1'b1;
        end else begin
          for (int i = 0; i < NUM_COUNTERS; i++) begin
            if (item.counter_sel == 2'(i)) begin
              rd_word = flags_r[i].latch ? latched_r[i] : count_r[i];
              if (flags_r[i].rmsb) begin
                rsp.rd             = rd_word[15:8];
                flags_nxt[i].rmsb  = 1'b0;
                flags_nxt[i].latch = 1'b0;
              end else begin
                rsp.rd            = rd_word[7:0];
                flags_nxt[i].rmsb = 1'b1;
              end
            end
          end
        end
      end
      OP_RD_PORTB: begin
        rsp.rd = flags_r[SPKR_COUNTER].out ? PORTB_OUT2 : 8'h00;
      end
      OP_WR_TIMER: begin
        if (item.counter_sel == SEL_READBACK) begin
          rsp.err = 1'b1;
        end else begin
          for (int i = 0; i < NUM_COUNTERS; i++) begin
            if (item.counter_sel == 2'(i)) begin
              if (flags_r[i].wmsb) begin
                // msb completes the count and arms the counter if the count is nonzero
                hi_count          = {item.data, count_r[i][7:0]};
                count_nxt[i]      = hi_count;
                if (hi_count != 16'h0000) ticks_nxt[i] = hi_count;
                flags_nxt[i].wmsb = 1'b0;
              end else begin
                count_nxt[i]      = {count_r[i][15:8], item.data};
                ticks_nxt[i]      = '0;
                flags_nxt[i].out  = 1'b0;
                flags_nxt[i].wmsb = 1'b1;
              end
            end
          end
        end
      end
      OP_WR_TCTRL: begin
        if (ctl_sel == SEL_READBACK) begin
          rsp.err = 1'b1;
        end else if (ctl_rw == RW_LATCH) begin
          for (int i = 0; i < NUM_COUNTERS; i++) begin
            if (ctl_sel == 2'(i) && !flags_r[i].latch) begin
              flags_nxt[i].latch = 1'b1;
              flags_nxt[i].rmsb  = 1'b0;
              latched_nxt[i]     = count_r[i];
            end
          end
        end else if (ctl_rw != RW_LSB_MSB || !mode_ok || item.data[0]) begin
          rsp.err = 1'b1;
        end else begin
          for (int i = 0; i < NUM_COUNTERS; i++) begin
            if (ctl_sel == 2'(i)) flags_nxt[i].mode = ctl_mode;
          end
        end
      end
      OP_PIT_TICK: begin
        // only mode 0 raises the output at terminal count
        for (int i = 0; i < NUM_COUNTERS; i++) begin
          if (ticks_r[i] != 16'h0000) begin
            ticks_nxt[i] = ticks_r[i] - 16'd1;
            if (ticks_r[i] == 16'd1 && flags_r[i].mode == MODE_INT) begin
              flags_nxt[i].out = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        count_r[i]   <= '0;
        latched_r[i] <= '0;
        ticks_r[i]   <= '0;
        flags_r[i]   <= '0;
      end
    end else if (go) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        count_r[i]   <= count_nxt[i];
        latched_r[i] <= latched_nxt[i];
        ticks_r[i]   <= ticks_nxt[i];
        flags_r[i]   <= flags_nxt[i];
      end
    end
  end

endmodule

// ----- src/lpcio_rtc.sv -----
// real-time clock: index, clock bytes, status a/b and periodic interrupt
module lpcio_rtc #(
  parameter int unsigned RTC_CLOCK_BYTES = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  lpcio_pkg::in_item_t  item,
  input  logic [31:0]          period,
  output lpcio_pkg::unit_rsp_t rsp,
  output logic                 fired
);
  import lpcio_pkg::*;

  logic [3:0]  index_r, index_nxt;
  logic [7:0]  bytes_r [RTC_CLOCK_BYTES];
  logic [7:0]  bytes_nxt [RTC_CLOCK_BYTES];
  logic [7:0]  status_a_r, status_a_nxt;
  logic [7:0]  status_b_r, status_b_nxt;
  logic [31:0] divider_r, divider_nxt;
  logic [32:0] div_inc;
  logic        byte_hit;

  assign div_inc = {1'b0, divider_r} + 33'd1;

  always_comb begin
    index_nxt    = index_r;
    status_a_nxt = status_a_r;
    status_b_nxt = status_b_r;
    divider_nxt  = divider_r;
    for (int i = 0; i < RTC_CLOCK_BYTES; i++) bytes_nxt[i] = bytes_r[i];
    rsp      = '0;
    fired    = 1'b0;
    byte_hit = 1'b0;
    case (item.opcode)
      OP_WR_RTC_INDEX: begin
        if (item.data <= RTC_IDX_MAX) index_nxt = item.data[3:0];
        else rsp.err = 1'b1;
      end
      OP_RD_RTC: begin
        if (index_r < RTC_IDX_STATUS_A) begin
          // clock bytes beyond the implemented ones read zero
          for (int i = 0; i < RTC_CLOCK_BYTES; i++) begin
            if (index_r == 4'(i)) rsp.rd = bytes_r[i];
          end
        end else if (index_r == RTC_IDX_STATUS_A) begin
          // update-in-progress toggles before the value is returned
          status_a_nxt = status_a_r ^ STATUS_A_UIP;
          rsp.rd       = status_a_nxt;
        end else if (index_r == RTC_IDX_STATUS_B) begin
          rsp.rd = status_b_r;
        end
      end
      OP_WR_RTC_DATA: begin
        if (index_r < RTC_IDX_STATUS_A) begin
          for (int i = 0; i < RTC_CLOCK_BYTES; i++) begin
            if (index_r == 4'(i)) begin
              bytes_nxt[i] = item.data;
              byte_hit     = 1'b1;
            end
          end
          rsp.err = !byte_hit;
        end else if (index_r == RTC_IDX_STATUS_A) begin
          if (item.data != STATUS_A_RESET) rsp.err = 1'b1;
          else status_a_nxt = item.data;
        end else if (index_r == RTC_IDX_STATUS_B) begin
          if ((item.data & ~STATUS_B_FREE) != STATUS_B_FIXED) begin
            rsp.err = 1'b1;
          end else begin
            // toggling the periodic enable restarts the divider
            if (item.data[STATUS_B_PIE] != status_b_r[STATUS_B_PIE]) divider_nxt = '0;
            status_b_nxt = item.data;
          end
        end else begin
          rsp.err = 1'b1;
        end
      end
      OP_RTC_TICK: begin
        // a period of zero fires on every tick while the periodic enable is set
        if (status_b_r[STATUS_B_PIE]) begin
          if (div_inc >= {1'b0, period}) begin
            fired       = 1'b1;
            divider_nxt = '0;
          end else begin
            divider_nxt = div_inc[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r    <= '0;
      status_a_r <= STATUS_A_RESET;
      status_b_r <= STATUS_B_RESET;
      divider_r  <= '0;
      for (int i = 0; i < RTC_CLOCK_BYTES; i++) bytes_r[i] <= '0;
    end else if (go) begin
      index_r    <= index_nxt;
      status_a_r <= status_a_nxt;
      status_b_r <= status_b_nxt;
      divider_r  <= divider_nxt;
      for (int i = 0; i < RTC_CLOCK_BYTES; i++) bytes_r[i] <= bytes_nxt[i];
    end
  end

endmodule

// ----- src/legacy_pc_pic_pit_rtc_ports_core.sv -----
// top level of the legacy pc i/o core: input stage, units and result stage
//
// Byte-port subset of a PC south bridge: an interrupt controller, three
// interval-timer counters and a real-time clock, driven by one bus access
// or event per item. The core takes one item every clock cycle while the
// input is not stalled. An accepted item sits in the input register, where
// every unit decodes it and updates its state, and its result is loaded
// into the output register, from which it is offered. The output register
// decouples the two sides: the input stalls only while both registers hold
// an item and the held result is stalled. The periodic rtc interval is set
// by cfg_wr_data (reset 1024 ticks); write it only while the core holds no
// item.
module legacy_pc_pic_pit_rtc_ports_core #(
  parameter int unsigned RTC_CLOCK_BYTES = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lpcio_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lpcio_pkg::out_item_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data
);
  import lpcio_pkg::*;

  in_item_t    in_item_r;
  logic        in_valid_r;
  out_item_t   out_item_r, out_item_nxt;
  logic        out_valid_r;
  logic [31:0] period_r;
  logic        go;
  logic        op_unknown;
  logic        any_err;
  logic        pic_irq;
  logic        rtc_fired;
  unit_rsp_t   pic_rsp, pit_rsp, rtc_rsp;

  // the held item proceeds when the result register is free or draining
  assign go       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !go;

  lpcio_pic u_pic (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_item_r),
    .rsp   (pic_rsp),
    .irq   (pic_irq)
  );

  lpcio_pit u_pit (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_item_r),
    .rsp   (pit_rsp)
  );

  lpcio_rtc #(
    .RTC_CLOCK_BYTES (RTC_CLOCK_BYTES)
  ) u_rtc (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .item   (in_item_r),
    .period (period_r),
    .rsp    (rtc_rsp),
    .fired  (rtc_fired)
  );

  // merge unit responses
  assign op_unknown = in_item_r.opcode > OP_IGNORE;
  assign any_err    = op_unknown || pic_rsp.err || pit_rsp.err || rtc_rsp.err;

  always_comb begin
    out_item_nxt.read_data = any_err ? 8'h00 : (pic_rsp.rd | pit_rsp.rd | rtc_rsp.rd);
    out_item_nxt.pic_irq   = pic_irq;
    out_item_nxt.rtc_irq   = rtc_fired;
    out_item_nxt.error     = any_err;
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_data;
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_item_r <= out_item_nxt;
  end

  // periodic interval register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= RTC_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      period_r <= cfg_wr_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// ----- src/lpcio_chk.sv -----
// port-level checker for the legacy pc i/o core, bound to the top level
`include "legacy_pc_pic_pit_rtc_ports_core_assert.svh"

module lpcio_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input lpcio_pkg::out_item_t out_data
);
  import lpcio_pkg::*;

  // a stalled result holds
  `LPCIO_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // an error result carries no read byte
  `LPCIO_ASSERT_IMP(a_err_zero, out_valid && out_data.error, out_data.read_data == 8'h00)

  // input backpressure only comes from a blocked result
  `LPCIO_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

  // a periodic interrupt never comes with an error
  `LPCIO_ASSERT_IMP(a_fire_ok, out_valid && out_data.rtc_irq, !out_data.error)

endmodule

bind legacy_pc_pic_pit_rtc_ports_core lpcio_chk u_lpcio_chk (.*);
